// File: rtl/core/spi_flash_command_sequencer_macros.svh
// Assertion macros for the SPI flash command sequencer.
// Depends on nothing; included by the top level.
`ifndef SPI_FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define SFCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked out of reset
`define SFCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SFCS_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SFCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/core/sfcs_pkg.sv
// Shared types and codes of the SPI flash command sequencer.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sfcs_pkg;
   localparam int DEF_PAGE_BYTES   = 256;
   localparam int DEF_ADDRESS_BITS = 24;
   localparam int FRAME_POS_W      = 10;
   localparam int PHASE_W          = 5;

   localparam logic [1:0] OP_COMMAND = 2'd0;
   localparam logic [1:0] OP_LOAD    = 2'd1;
   localparam logic [1:0] OP_WIRE    = 2'd2;

   localparam logic [2:0] CMD_ID     = 3'd0;
   localparam logic [2:0] CMD_STATUS = 3'd1;
   localparam logic [2:0] CMD_WSR    = 3'd2;
   localparam logic [2:0] CMD_WEN    = 3'd3;
   localparam logic [2:0] CMD_WDIS   = 3'd4;
   localparam logic [2:0] CMD_ERASE  = 3'd5;
   localparam logic [2:0] CMD_PROG   = 3'd6;
   localparam logic [2:0] CMD_READ   = 3'd7;

   localparam logic [1:0] KIND_SEND    = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_HOST    = 2'd2;
   localparam logic [1:0] KIND_DONE    = 2'd3;

   localparam logic [PHASE_W-1:0] PH_IDLE  = 5'd0;
   localparam logic [PHASE_W-1:0] PH_WSEN  = 5'd1;
   localparam logic [PHASE_W-1:0] PH_WSR   = 5'd2;
   localparam logic [PHASE_W-1:0] PH_WEN   = 5'd3;
   localparam logic [PHASE_W-1:0] PH_WDIS  = 5'd4;
   localparam logic [PHASE_W-1:0] PH_ID    = 5'd5;
   localparam logic [PHASE_W-1:0] PH_STAT  = 5'd6;
   localparam logic [PHASE_W-1:0] PH_POLL  = 5'd7;
   localparam logic [PHASE_W-1:0] PH_ERASE = 5'd8;
   localparam logic [PHASE_W-1:0] PH_PROG  = 5'd9;
   localparam logic [PHASE_W-1:0] PH_READ  = 5'd10;

   localparam logic [7:0] OPC_WSEN   = 8'h50;
   localparam logic [7:0] OPC_WSR    = 8'h01;
   localparam logic [7:0] OPC_WEN    = 8'h06;
   localparam logic [7:0] OPC_WDIS   = 8'h04;
   localparam logic [7:0] OPC_ID     = 8'h90;
   localparam logic [7:0] OPC_STATUS = 8'h05;
   localparam logic [7:0] OPC_ERASE  = 8'h20;
   localparam logic [7:0] OPC_PROG   = 8'h02;
   localparam logic [7:0] OPC_READ   = 8'h0b;

   localparam logic CSR_SINGLE  = 1'b0;
   localparam logic CSR_REVERSE = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  mosi_byte;
      logic [15:0] host_data;
      logic        last;
   } sfcs_result_type;

   function automatic logic [7:0] sfcs_rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[i];
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// File: rtl/core/sfcs_ram.sv
// Generic single-port-write RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module sfcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/core/sfcs_step.sv
// Sequencer step: next state and up to three results for one request.
// Depends on sfcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfcs_step #(
   parameter int PAGE_BYTES   = sfcs_pkg::DEF_PAGE_BYTES,
   parameter int ADDRESS_BITS = sfcs_pkg::DEF_ADDRESS_BITS,
   parameter int IDX_W        = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1,
   parameter int DPOS_W       = $clog2(PAGE_BYTES + 1)
) (
   input  wire logic [1:0]                      op,
   input  wire logic [2:0]                      cmd,
   input  wire logic [23:0]                     addr,
   input  wire logic [7:0]                      data_in,
   input  wire logic [8:0]                      len,
   input  wire logic [7:0]                      miso,
   input  wire logic                            cfg_single,
   input  wire logic                            cfg_reverse,
   input  wire logic [7:0]                      ram_q,
   input  wire logic [sfcs_pkg::PHASE_W-1:0]     phase,
   input  wire logic [2:0]                      acmd,
   input  wire logic [ADDRESS_BITS-1:0]         caddr,
   input  wire logic [8:0]                      left,
   input  wire logic [IDX_W-1:0]                pidx,
   input  wire logic [7:0]                      idh,
   input  wire logic [sfcs_pkg::FRAME_POS_W-1:0] fpos,
   input  wire logic [DPOS_W-1:0]               dpos,
   input  wire logic [7:0]                      sval,
   input  wire logic                            lsing,
   input  wire logic                            lrev,
   output logic [sfcs_pkg::PHASE_W-1:0]          phase_n,
   output logic [2:0]                           acmd_n,
   output logic [ADDRESS_BITS-1:0]              caddr_n,
   output logic [8:0]                           left_n,
   output logic [IDX_W-1:0]                     pidx_n,
   output logic [7:0]                           idh_n,
   output logic [sfcs_pkg::FRAME_POS_W-1:0]      fpos_n,
   output logic [DPOS_W-1:0]                    dpos_n,
   output logic [7:0]                           sval_n,
   output logic                                 lsing_n,
   output logic                                 lrev_n,
   output logic                                 ram_we,
   output sfcs_pkg::sfcs_result_type            res [3],
   output logic [1:0]                           res_n
);
   import sfcs_pkg::*;

   localparam int NB  = (ADDRESS_BITS + 7) / 8;
   localparam int XW  = (ADDRESS_BITS > 24) ? ADDRESS_BITS : 24;
   localparam int FPW = FRAME_POS_W;

   logic [XW-1:0]  addr_x;
   logic [FPW-1:0] fp1;
   logic [FPW-1:0] flen;
   logic [8:0]     len_sat;
   logic           busy;

   function automatic logic [7:0] frame_byte(
      input logic [PHASE_W-1:0]      ph,
      input logic [FPW-1:0]          p,
      input logic [ADDRESS_BITS-1:0] ca,
      input logic [7:0]              sv,
      input logic [7:0]              rq,
      input logic                    rv
   );
      logic [NB*8-1:0] pad;
      logic [7:0]      ab;
      logic [7:0]      b;
      pad = (NB*8)'(ca);
      ab  = 8'd0;
      for (int j = 0; j < NB; j++) begin
         if (p == FPW'(j + 1)) begin
            ab = pad[8*(NB-1-j) +: 8];
         end
      end
      case (ph)
         PH_WSEN:  b = OPC_WSEN;
         PH_WSR:   b = (p == '0) ? OPC_WSR : sv;
         PH_WEN:   b = OPC_WEN;
         PH_WDIS:  b = OPC_WDIS;
         PH_ID:    b = (p == '0) ? OPC_ID : 8'd0;
         PH_STAT,
         PH_POLL:  b = (p == '0) ? OPC_STATUS : 8'd0;
         PH_ERASE: b = (p == '0) ? OPC_ERASE : ab;
         PH_PROG: begin
            if (p == '0) begin
               b = OPC_PROG;
            end else if (p <= FPW'(NB)) begin
               b = ab;
            end else begin
               b = rv ? sfcs_rev8(rq) : rq;
            end
         end
         PH_READ: begin
            if (p == '0) begin
               b = OPC_READ;
            end else if (p <= FPW'(NB)) begin
               b = ab;
            end else begin
               b = 8'd0;
            end
         end
         default:  b = 8'd0;
      endcase
      return b;
   endfunction

   assign addr_x  = XW'(addr);
   assign len_sat = (32'(len) > PAGE_BYTES) ? 9'(PAGE_BYTES) : len;
   assign fp1     = fpos + FPW'(1);

   always_comb begin
      case (phase)
         PH_WSR, PH_STAT, PH_POLL: flen = FPW'(2);
         PH_ID:    flen = FPW'(6);
         PH_ERASE: flen = FPW'(1 + NB);
         PH_PROG:  flen = FPW'(1 + NB) + (lsing ? FPW'(1) : FPW'(left));
         PH_READ:  flen = FPW'(2 + NB) + FPW'(left);
         default:  flen = FPW'(1);
      endcase
   end

   always_comb begin
      phase_n = phase;
      acmd_n  = acmd;
      caddr_n = caddr;
      left_n  = left;
      pidx_n  = pidx;
      idh_n   = idh;
      fpos_n  = fpos;
      dpos_n  = dpos;
      sval_n  = sval;
      lsing_n = lsing;
      lrev_n  = lrev;
      ram_we  = 1'b0;
      busy    = 1'b0;
      res_n   = 2'd0;
      for (int i = 0; i < 3; i++) begin
         res[i] = '0;
      end

      if (op == OP_COMMAND && phase == PH_IDLE) begin
         acmd_n  = cmd;
         caddr_n = addr_x[ADDRESS_BITS-1:0];
         left_n  = 9'd0;
         dpos_n  = '0;
         fpos_n  = '0;
         res_n   = 2'd1;
         res[0].kind = KIND_SEND;
         case (cmd)
            CMD_ID:     phase_n = PH_ID;
            CMD_STATUS: phase_n = PH_STAT;
            CMD_WSR: begin
               sval_n  = data_in;
               phase_n = PH_WSEN;
            end
            CMD_WEN,
            CMD_ERASE:  phase_n = PH_WEN;
            CMD_WDIS:   phase_n = PH_WDIS;
            CMD_PROG: begin
               lsing_n = cfg_single;
               lrev_n  = cfg_reverse;
               pidx_n  = '0;
               left_n  = len_sat;
               if (cfg_single && len_sat == 9'd0) begin
                  phase_n     = PH_IDLE;
                  res[0].kind = KIND_DONE;
               end else begin
                  phase_n = PH_WEN;
               end
            end
            default: begin
               left_n  = len;
               phase_n = PH_READ;
            end
         endcase
         if (res[0].kind == KIND_SEND) begin
            res[0].mosi_byte = frame_byte(phase_n, '0, caddr_n, sval_n, ram_q, lrev_n);
         end
      end else if (op == OP_LOAD && phase == PH_IDLE) begin
         ram_we = 1'b1;
         pidx_n = (32'(pidx) == PAGE_BYTES - 1) ? '0 : pidx + IDX_W'(1);
      end else if (op == OP_WIRE && phase != PH_IDLE) begin
         if (phase == PH_ID && fpos == FPW'(4)) begin
            idh_n = miso;
         end
         if ((phase == PH_ID && fpos == FPW'(5)) || (phase == PH_STAT && fpos == FPW'(1))
               || (phase == PH_READ && fpos >= FPW'(2 + NB))) begin
            res[0].kind      = KIND_HOST;
            res[0].host_data = (phase == PH_ID) ? {idh, miso} : 16'(miso);
            res_n            = 2'd1;
         end
         if (phase == PH_POLL && fpos == FPW'(1)) begin
            busy = miso[0];
         end
         fpos_n = fp1;
         if (fp1 < flen) begin
            res[res_n].kind      = KIND_SEND;
            res[res_n].mosi_byte = frame_byte(phase, fp1, caddr, sval, ram_q, lrev);
            res_n                = res_n + 2'd1;
         end else begin
            res[res_n].kind = KIND_RELEASE;
            res_n           = res_n + 2'd1;
            phase_n         = PH_IDLE;
            case (phase)
               PH_WSEN: phase_n = PH_WSR;
               PH_WEN: begin
                  if (acmd == CMD_ERASE) begin
                     phase_n = PH_ERASE;
                  end else if (acmd == CMD_PROG) begin
                     phase_n = PH_PROG;
                  end
               end
               PH_ERASE: phase_n = PH_POLL;
               PH_PROG: begin
                  if (lsing) begin
                     if (left != 9'd0) begin
                        left_n = left - 9'd1;
                     end
                     dpos_n  = dpos + DPOS_W'(1);
                     caddr_n = caddr + ADDRESS_BITS'(1);
                  end else begin
                     left_n = 9'd0;
                  end
                  phase_n = PH_POLL;
               end
               PH_POLL: begin
                  if (busy) begin
                     phase_n = PH_POLL;
                  end else if (acmd == CMD_PROG && lsing && left != 9'd0) begin
                     phase_n = PH_WEN;
                  end
               end
               default: phase_n = PH_IDLE;
            endcase
            fpos_n = '0;
            if (phase_n == PH_IDLE) begin
               res[res_n].kind = KIND_DONE;
            end else begin
               res[res_n].kind      = KIND_SEND;
               res[res_n].mosi_byte = frame_byte(phase_n, '0, caddr_n, sval, ram_q, lrev);
            end
            res_n = res_n + 2'd1;
         end
      end

      if (res_n != 2'd0) begin
         res[res_n - 2'd1].last = 1'b1;
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/sfcs_rspq.sv
// Result buffer: holds the results of one request and hands them out in order.
// Depends on sfcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfcs_rspq (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire sfcs_pkg::sfcs_result_type  res [3],
   input  wire logic [1:0]                 res_n,
   output logic                            space,
   output logic [1:0]                      level,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [23:0]                     rsp_tdata,
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast
);
   import sfcs_pkg::*;

   sfcs_result_type q_ff [3];
   logic [1:0]      cnt_ff;
   logic            pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign space      = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);
   assign level      = cnt_ff;
   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tdata  = {q_ff[0].host_data, q_ff[0].mosi_byte};
   assign rsp_tuser  = q_ff[0].kind;
   assign rsp_tlast  = q_ff[0].last;

   always_ff @(posedge clock) begin
      if (load) begin
         q_ff <= res;
      end else if (pop) begin
         q_ff[0] <= q_ff[1];
         q_ff[1] <= q_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (load) begin
         cnt_ff <= res_n;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/spi_flash_command_sequencer.sv
// Top level of the SPI flash command sequencer: request register, state, page RAM.
// Depends on sfcs_pkg, sfcs_step, sfcs_rspq, sfcs_ram and the macros header.
//
//   channel   direction  group                          content
//   request   in         req_tvalid/tready/tdata/tuser  operation and its operands
//   response  out        rsp_tvalid/tready/tdata/tuser  one send, release, host or done result
//   csr       in         csr_we/index/wdata             option registers
//
// A request is held in the input register, then the step logic writes its
// zero to three results into the result buffer, which hands out one per
// cycle while the response port is ready; the buffer takes the next request
// as the last result of the one before leaves. Reset is synchronous and
// clears all control state; the page RAM is not cleared. A stalled response
// holds the buffer and, through it, the input register.
`timescale 1ns / 1ps
`default_nettype none
`include "spi_flash_command_sequencer_macros.svh"
module spi_flash_command_sequencer #(
   parameter int PAGE_BYTES   = sfcs_pkg::DEF_PAGE_BYTES,
   parameter int ADDRESS_BITS = sfcs_pkg::DEF_ADDRESS_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // command[2:0], address[26:3], data_in[34:27], length[43:35], miso_byte[51:44]
   input  wire logic [55:0] req_tdata,
   // operation[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // mosi_byte[7:0], host_data[23:8]
   output logic [23:0]      rsp_tdata,
   // kind[1:0]
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [0:0]  csr_wdata
);
   import sfcs_pkg::*;

   localparam int IDX_W  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
   localparam int DPOS_W = $clog2(PAGE_BYTES + 1);
   localparam int NB     = (ADDRESS_BITS + 7) / 8;

   // request register
   logic        in_valid_ff;
   logic [55:0] in_data_ff;
   logic [1:0]  in_op_ff;
   logic        fire;
   logic        space;
   logic [1:0]  level;

   // option registers
   logic cfg_single_ff;
   logic cfg_reverse_ff;

   // sequencer state and next values
   logic [PHASE_W-1:0]      phase_ff,  phase_in,  phase_s;
   logic [2:0]              acmd_ff,   acmd_in,   acmd_s;
   logic [ADDRESS_BITS-1:0] caddr_ff,  caddr_in,  caddr_s;
   logic [8:0]              left_ff,   left_in,   left_s;
   logic [IDX_W-1:0]        pidx_ff,   pidx_in,   pidx_s;
   logic [7:0]              idh_ff,    idh_in,    idh_s;
   logic [FRAME_POS_W-1:0]  fpos_ff,   fpos_in,   fpos_s;
   logic [DPOS_W-1:0]       dpos_ff,   dpos_in,   dpos_s;
   logic [7:0]              sval_ff,   sval_in,   sval_s;
   logic                    lsing_ff,  lsing_in,  lsing_s;
   logic                    lrev_ff,   lrev_in,   lrev_s;

   logic                    ram_we_s;
   logic                    ram_we;
   logic [7:0]              ram_q;
   logic [IDX_W-1:0]        ram_rd_addr;
   logic [FRAME_POS_W-1:0]  fpos_off;
   sfcs_result_type         res [3];
   logic [1:0]              res_n;

   // take a request when the register is empty or is being consumed
   assign fire       = in_valid_ff && space;
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_op_ff   <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_single_ff  <= 1'b0;
         cfg_reverse_ff <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == CSR_SINGLE) begin
            cfg_single_ff <= csr_wdata[0];
         end
         if (csr_index == CSR_REVERSE) begin
            cfg_reverse_ff <= csr_wdata[0];
         end
      end
   end

   sfcs_step #(
      .PAGE_BYTES   (PAGE_BYTES),
      .ADDRESS_BITS (ADDRESS_BITS),
      .IDX_W        (IDX_W),
      .DPOS_W       (DPOS_W)
   ) u_step (
      .op          (in_op_ff),
      .cmd         (in_data_ff[2:0]),
      .addr        (in_data_ff[26:3]),
      .data_in     (in_data_ff[34:27]),
      .len         (in_data_ff[43:35]),
      .miso        (in_data_ff[51:44]),
      .cfg_single  (cfg_single_ff),
      .cfg_reverse (cfg_reverse_ff),
      .ram_q       (ram_q),
      .phase       (phase_ff),
      .acmd        (acmd_ff),
      .caddr       (caddr_ff),
      .left        (left_ff),
      .pidx        (pidx_ff),
      .idh         (idh_ff),
      .fpos        (fpos_ff),
      .dpos        (dpos_ff),
      .sval        (sval_ff),
      .lsing       (lsing_ff),
      .lrev        (lrev_ff),
      .phase_n     (phase_s),
      .acmd_n      (acmd_s),
      .caddr_n     (caddr_s),
      .left_n      (left_s),
      .pidx_n      (pidx_s),
      .idh_n       (idh_s),
      .fpos_n      (fpos_s),
      .dpos_n      (dpos_s),
      .sval_n      (sval_s),
      .lsing_n     (lsing_s),
      .lrev_n      (lrev_s),
      .ram_we      (ram_we_s),
      .res         (res),
      .res_n       (res_n)
   );

   // advance the state only when the request is consumed
   assign phase_in = fire ? phase_s : phase_ff;
   assign acmd_in  = fire ? acmd_s  : acmd_ff;
   assign caddr_in = fire ? caddr_s : caddr_ff;
   assign left_in  = fire ? left_s  : left_ff;
   assign pidx_in  = fire ? pidx_s  : pidx_ff;
   assign idh_in   = fire ? idh_s   : idh_ff;
   assign fpos_in  = fire ? fpos_s  : fpos_ff;
   assign dpos_in  = fire ? dpos_s  : dpos_ff;
   assign sval_in  = fire ? sval_s  : sval_ff;
   assign lsing_in = fire ? lsing_s : lsing_ff;
   assign lrev_in  = fire ? lrev_s  : lrev_ff;
   assign ram_we   = fire && ram_we_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acmd_ff  <= 3'd0;
         caddr_ff <= '0;
         left_ff  <= 9'd0;
         pidx_ff  <= '0;
         idh_ff   <= 8'd0;
         fpos_ff  <= '0;
         dpos_ff  <= '0;
         sval_ff  <= 8'd0;
         lsing_ff <= 1'b0;
         lrev_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         acmd_ff  <= acmd_in;
         caddr_ff <= caddr_in;
         left_ff  <= left_in;
         pidx_ff  <= pidx_in;
         idh_ff   <= idh_in;
         fpos_ff  <= fpos_in;
         dpos_ff  <= dpos_in;
         sval_ff  <= sval_in;
         lsing_ff <= lsing_in;
         lrev_ff  <= lrev_in;
      end
   end

   // Prefetch the page byte the next wire byte will send: in single-byte mode
   // the data position, otherwise the frame position past opcode and address.
   assign fpos_off    = fpos_in - FRAME_POS_W'(NB);
   assign ram_rd_addr = lsing_in ? dpos_in[IDX_W-1:0] : IDX_W'(fpos_off);

   sfcs_ram #(
      .WIDTH (8),
      .DEPTH (PAGE_BYTES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pidx_ff),
      .wr_data (in_data_ff[34:27]),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_q)
   );

   sfcs_rspq u_rspq (
      .clock      (clock),
      .reset      (reset),
      .load       (fire && res_n != 2'd0),
      .res        (res),
      .res_n      (res_n),
      .space      (space),
      .level      (level),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a wire byte during a command always answers
   `SFCS_ASSERT_NOW(a_wire_answers, clock, reset, fire && in_op_ff == OP_WIRE && phase_ff != PH_IDLE, res_n != 2'd0, "wire byte gave no result")
   // the final result of a request carries last
   `SFCS_ASSERT_NOW(a_last_marked, clock, reset, rsp_tvalid && level == 2'd1, rsp_tlast, "final result without last")
   // a done result leaves the sequencer idle
   `SFCS_ASSERT_NEXT(a_done_idle, clock, reset, fire && res_n != 2'd0 && res[res_n - 2'd1].kind == KIND_DONE, phase_ff == PH_IDLE, "done without idle")
endmodule
`default_nettype wire

// File: sim/tb_spi_flash_command_sequencer.sv
// Self-checking testbench for the SPI flash command sequencer: drives host, page-load
// and wire requests, predicts every result in SystemVerilog and compares them in order.
// Depends on sfcs_pkg and the spi_flash_command_sequencer RTL.
`timescale 1ns / 1ps
module tb_spi_flash_command_sequencer;
   import sfcs_pkg::*;

   localparam int ADDR_BYTES  = (DEF_ADDRESS_BITS + 7) / 8;
   // page entries loaded up front; no program is longer than this
   localparam int PAGE_LOADED = 8;
   localparam logic [1:0] OP_NONE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [0:0]  csr_wdata = '0;

   spi_flash_command_sequencer i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Sequencer predictor: its own copy of state and options
   // ---------------------------------------------------------------------------
   logic [PHASE_W-1:0] seq_phase = PH_IDLE;
   logic [2:0]  seq_cmd = CMD_ID;
   logic [23:0] seq_addr = '0;
   int          seq_left = 0;
   logic [7:0]  page_copy [256];
   int          page_ptr = 0;
   logic [7:0]  id_maker = '0;
   int          byte_pos = 0;
   int          data_ptr = 0;
   logic [7:0]  wsr_value = '0;
   logic        held_single = 1'b0, held_reverse = 1'b0;
   logic        opt_single = 1'b0, opt_reverse = 1'b0;

   sfcs_result_type expected_results [$];
   sfcs_result_type step_results [$];

   int mismatches = 0;
   int results_seen = 0;
   int requests_sent = 0;
   int commands_done = 0;

   function automatic logic [7:0] flip_bits(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[i] = v[7-i];
      return r;
   endfunction

   function automatic void add_result(input logic [1:0] k, input logic [7:0] mosi,
                                      input logic [15:0] host);
      sfcs_result_type r;
      r.kind = k; r.mosi_byte = mosi; r.host_data = host; r.last = 1'b0;
      step_results.push_back(r);
   endfunction

   function automatic int frame_bytes();
      case (seq_phase)
         PH_WSR, PH_STAT, PH_POLL: return 2;
         PH_ID:    return 6;
         PH_ERASE: return 1 + ADDR_BYTES;
         PH_PROG:  return 1 + ADDR_BYTES + (held_single ? 1 : seq_left);
         PH_READ:  return 2 + ADDR_BYTES + seq_left;
         default:  return 1;
      endcase
   endfunction

   function automatic logic [7:0] addr_part(input int k);
      return 8'(seq_addr >> (8 * (ADDR_BYTES - 1 - k)));
   endfunction

   function automatic logic [7:0] frame_value(input int p);
      int idx;
      case (seq_phase)
         PH_WSEN: return OPC_WSEN;
         PH_WSR:  return p == 0 ? OPC_WSR : wsr_value;
         PH_WEN:  return OPC_WEN;
         PH_WDIS: return OPC_WDIS;
         PH_ID:   return p == 0 ? OPC_ID : 8'h00;
         PH_STAT, PH_POLL: return p == 0 ? OPC_STATUS : 8'h00;
         PH_ERASE: return p == 0 ? OPC_ERASE : addr_part(p - 1);
         PH_PROG: begin
            if (p == 0) return OPC_PROG;
            if (p <= ADDR_BYTES) return addr_part(p - 1);
            idx = held_single ? data_ptr : p - 1 - ADDR_BYTES;
            return held_reverse ? flip_bits(page_copy[idx]) : page_copy[idx];
         end
         PH_READ: begin
            if (p == 0) return OPC_READ;
            if (p <= ADDR_BYTES) return addr_part(p - 1);
            return 8'h00;
         end
         default: return 8'h00;
      endcase
   endfunction

   function automatic void open_frame(input logic [PHASE_W-1:0] p);
      seq_phase = p;
      byte_pos = 0;
      add_result(KIND_SEND, frame_value(0), 16'h0000);
   endfunction

   function automatic void close_command();
      seq_phase = PH_IDLE;
      add_result(KIND_DONE, 8'h00, 16'h0000);
   endfunction

   function automatic void start_host_command(input logic [2:0] cmd, input logic [23:0] addr,
                                              input logic [7:0] din, input logic [8:0] len);
      seq_cmd = cmd;
      seq_addr = addr;
      seq_left = 0;
      data_ptr = 0;
      case (cmd)
         CMD_ID:     open_frame(PH_ID);
         CMD_STATUS: open_frame(PH_STAT);
         CMD_WSR: begin
            wsr_value = din;
            open_frame(PH_WSEN);
         end
         CMD_WEN, CMD_ERASE: open_frame(PH_WEN);
         CMD_WDIS: open_frame(PH_WDIS);
         CMD_PROG: begin
            held_single = opt_single;
            held_reverse = opt_reverse;
            page_ptr = 0;
            seq_left = len > 256 ? 256 : len;
            if (held_single && seq_left == 0) close_command();
            else open_frame(PH_WEN);
         end
         default: begin
            seq_left = len;
            open_frame(PH_READ);
         end
      endcase
   endfunction

   function automatic void take_wire_byte(input logic [7:0] m);
      logic busy;
      busy = 1'b0;
      if (seq_phase == PH_ID && byte_pos == 4) id_maker = m;
      if (seq_phase == PH_ID && byte_pos == 5) add_result(KIND_HOST, 8'h00, {id_maker, m});
      if (seq_phase == PH_STAT && byte_pos == 1) add_result(KIND_HOST, 8'h00, {8'h00, m});
      if (seq_phase == PH_READ && byte_pos >= 2 + ADDR_BYTES)
         add_result(KIND_HOST, 8'h00, {8'h00, m});
      if (seq_phase == PH_POLL && byte_pos == 1) busy = m[0];
      byte_pos++;
      if (byte_pos < frame_bytes()) begin
         add_result(KIND_SEND, frame_value(byte_pos), 16'h0000);
         return;
      end
      add_result(KIND_RELEASE, 8'h00, 16'h0000);
      case (seq_phase)
         PH_WSEN: open_frame(PH_WSR);
         PH_WEN: begin
            if (seq_cmd == CMD_ERASE) open_frame(PH_ERASE);
            else if (seq_cmd == CMD_PROG) open_frame(PH_PROG);
            else close_command();
         end
         PH_ERASE: open_frame(PH_POLL);
         PH_PROG: begin
            if (held_single) begin
               if (seq_left > 0) seq_left--;
               data_ptr++;
               seq_addr = seq_addr + 24'd1;
            end else begin
               seq_left = 0;
            end
            open_frame(PH_POLL);
         end
         PH_POLL: begin
            if (busy) open_frame(PH_POLL);
            else if (seq_cmd == CMD_PROG && held_single && seq_left > 0) open_frame(PH_WEN);
            else close_command();
         end
         default: close_command();
      endcase
   endfunction

   // Work out the results of one accepted request and queue them for checking.
   function automatic void predict_request(input logic [1:0] op, input logic [2:0] cmd,
                                           input logic [23:0] addr, input logic [7:0] din,
                                           input logic [8:0] len, input logic [7:0] miso);
      sfcs_result_type r;
      step_results.delete();
      if (op == OP_COMMAND) begin
         if (seq_phase == PH_IDLE) start_host_command(cmd, addr, din, len);
      end else if (op == OP_LOAD) begin
         if (seq_phase == PH_IDLE) begin
            page_copy[page_ptr] = din;
            page_ptr = (page_ptr + 1) % 256;
         end
      end else if (op == OP_WIRE) begin
         if (seq_phase != PH_IDLE) take_wire_byte(miso);
      end
      foreach (step_results[i]) begin
         r = step_results[i];
         r.last = (i == step_results.size() - 1);
         if (r.kind == KIND_DONE) commands_done++;
         expected_results.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: bursts of back-to-back requests with random gaps
   // ---------------------------------------------------------------------------
   int burst_left = 0;

   task automatic send_request(input logic [1:0] op, input logic [2:0] cmd,
                               input logic [23:0] addr, input logic [7:0] din,
                               input logic [8:0] len, input logic [7:0] miso);
      int gap;
      req_tdata <= {4'h0, miso, len, din, addr, cmd};
      req_tuser <= op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_request(op, cmd, addr, din, len, miso);
      requests_sent++;
      // at the end of a burst drop valid for a random gap
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 6);
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic host_command(input logic [2:0] cmd, input logic [23:0] addr,
                               input logic [7:0] din, input logic [8:0] len);
      send_request(OP_COMMAND, cmd, addr, din, len, 8'($urandom));
   endtask

   // Answer every frame byte until the command completes; polls read busy now and then,
   // and ignored requests are mixed in as noise.
   task automatic answer_wire(input int busy_odds);
      logic [7:0] m;
      while (seq_phase != PH_IDLE) begin
         m = 8'($urandom);
         if (seq_phase == PH_POLL) m[0] = ($urandom_range(0, 99) < busy_odds);
         if ($urandom_range(0, 11) == 0)
            send_request($urandom_range(0, 1) ? OP_COMMAND : OP_LOAD, 3'($urandom),
                         24'($urandom), 8'($urandom), 9'($urandom), 8'($urandom));
         send_request(OP_WIRE, 3'($urandom), 24'($urandom), 8'($urandom), 9'($urandom), m);
      end
   endtask

   task automatic run_command(input logic [2:0] cmd, input logic [23:0] addr,
                              input logic [7:0] din, input logic [8:0] len);
      host_command(cmd, addr, din, len);
      answer_wire(30);
   endtask

   // Hold until every result is in, then let the pipeline drain before a register write.
   task automatic write_option(input logic [0:0] idx, input logic val);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_SINGLE) opt_single = val;
      else opt_reverse = val;
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      sfcs_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d mosi %02h host %04h last %0d",
                        rsp_tuser, rsp_tdata[7:0], rsp_tdata[23:8], rsp_tlast);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata[7:0] !== want.mosi_byte ||
                rsp_tdata[23:8] !== want.host_data || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected kind %0d mosi %02h host %04h last %0d, got kind %0d mosi %02h host %04h last %0d",
                           results_seen, want.kind, want.mosi_byte, want.host_data, want.last,
                           rsp_tuser, rsp_tdata[7:0], rsp_tdata[23:8], rsp_tlast);
            end
         end
      end
   end

   // Receiver stall pattern: free-running stretches alternate with random stalls.
   int stall_cnt = 0;
   always @(posedge clock) begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt[6]) rsp_tready <= 1'b1;
      else if (stall_cnt[5]) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= ($urandom_range(0, 2) == 0);
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   // Load the first page entries; programs stay within them, so none reads an
   // unwritten entry.
   task automatic fill_page(input int count);
      for (int i = 0; i < count; i++)
         send_request(OP_LOAD, 3'($urandom), 24'($urandom), 8'($urandom), 9'($urandom),
                      8'($urandom));
   endtask

   task automatic test_ignored_when_idle();
      send_request(OP_WIRE, CMD_READ, 24'hffffff, 8'hff, 9'h1ff, 8'hff);
      send_request(OP_NONE, CMD_PROG, 24'hffffff, 8'hff, 9'h1ff, 8'hff);
   endtask

   task automatic test_every_command();
      run_command(CMD_ID, 24'h000000, 8'h00, 9'd0);
      run_command(CMD_STATUS, 24'h000000, 8'h00, 9'd0);
      run_command(CMD_WSR, 24'h000000, 8'hff, 9'd0);
      run_command(CMD_WSR, 24'hffffff, 8'h00, 9'd0);
      run_command(CMD_WEN, 24'h123456, 8'h00, 9'd0);
      run_command(CMD_WDIS, 24'h000000, 8'h00, 9'd0);
      run_command(CMD_ERASE, 24'hffffff, 8'h00, 9'd0);
      run_command(CMD_ERASE, 24'h000000, 8'h00, 9'd0);
      run_command(CMD_READ, 24'hffffff, 8'h00, 9'd0);
      run_command(CMD_READ, 24'h800001, 8'h00, 9'd3);
   endtask

   task automatic test_page_program_extremes();
      run_command(CMD_PROG, 24'hfffffe, 8'h00, 9'd0);
      run_command(CMD_PROG, 24'h000100, 8'h00, 9'(PAGE_LOADED)); // every loaded entry
      run_command(CMD_READ, 24'h00ff00, 8'h00, 9'd6);
   endtask

   task automatic test_single_byte_mode();
      write_option(CSR_SINGLE, 1'b1);
      write_option(CSR_REVERSE, 1'b1);
      run_command(CMD_PROG, 24'h000000, 8'h00, 9'd0);      // completes at once
      run_command(CMD_PROG, 24'hfffffe, 8'h00, 9'd3);      // address wraps
      write_option(CSR_SINGLE, 1'b0);
      run_command(CMD_PROG, 24'h0a0b0c, 8'h00, 9'd5);
      write_option(CSR_REVERSE, 1'b0);
   endtask

   // Mostly well-formed commands with short lengths, plus loads and ignored requests.
   task automatic test_random_traffic(input int count);
      logic [8:0] len;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0: send_request($urandom_range(0, 1) ? OP_WIRE : OP_NONE, 3'($urandom),
                            24'($urandom), 8'($urandom), 9'($urandom), 8'($urandom));
            1: send_request(OP_LOAD, 3'($urandom), 24'($urandom), 8'($urandom),
                            9'($urandom), 8'($urandom));
            default: begin
               len = 9'($urandom_range(0, 6));
               host_command(3'($urandom), 24'($urandom), 8'($urandom), len);
               answer_wire($urandom_range(0, 60));
            end
         endcase
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_ignored_when_idle();
      fill_page(PAGE_LOADED);
      test_every_command();
      test_page_program_extremes();
      test_single_byte_mode();
      test_random_traffic(3);
      write_option(CSR_SINGLE, 1'b1);
      test_random_traffic(3);
      write_option(CSR_REVERSE, 1'b1);
      test_random_traffic(3);
      write_option(CSR_SINGLE, 1'b0);
      test_random_traffic(3);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d requests, %0d results, %0d completed commands over four option settings",
               requests_sent, results_seen, commands_done);
      if (mismatches == 0) begin
         $display("tb_spi_flash_command_sequencer: done, clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_spi_flash_command_sequencer: done, errors");
      end
      $finish;
   end

   initial begin
      #400_000;
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("tb_spi_flash_command_sequencer: done, errors");
      $finish;
   end
endmodule
